[sv/ctcr_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// ctcr_pkg
// Shared sizes, widths, control types and states of the causal convolution core.
// ---------------------------------------------------------------------------
package ctcr_pkg;

	// layer geometry
	localparam int IN_CH  = 10;
	localparam int OUT_CH = 4;
	localparam int TAPS   = 3;

	localparam int HIST_SIZE   = TAPS * IN_CH;
	localparam int WEIGHT_SIZE = TAPS * OUT_CH * IN_CH;

	// address and counter widths
	localparam int HA_W = (HIST_SIZE > 1) ? $clog2(HIST_SIZE) : 1;
	localparam int WA_W = (WEIGHT_SIZE > 1) ? $clog2(WEIGHT_SIZE) : 1;
	localparam int IC_W = $clog2(IN_CH + 1);
	localparam int OC_W = $clog2(OUT_CH + 1);
	localparam int TK_W = $clog2(TAPS + 1);

	// data widths
	localparam int DATA_W = 16;
	localparam int PROD_W = 2 * DATA_W;
	localparam int ACC_W  = PROD_W + $clog2(HIST_SIZE + 1);
	localparam int ACT_W  = 15;
	localparam int FRAC_W = 12;

	// opcodes of an input transaction
	localparam logic OP_LOAD   = 1'b0;
	localparam logic OP_SAMPLE = 1'b1;

	// sequencer states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ISSUE,
		ST_WAIT,
		ST_PUT
	} state_t;

	// control that travels with one operand pair through the mac
	typedef struct packed {
		logic vld;
		logic first;
		logic last;
	} mac_ctl_t;

endpackage
`default_nettype wire

[sv/ctcr_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// ctcr channel interfaces
// Valid/ready channels for input items and for activation results.
// ---------------------------------------------------------------------------
interface ctcr_in_if;
	logic                     valid;
	logic                     ready;
	logic                     opcode;
	logic [6:0]               index;
	logic signed [15:0]       value;

	modport source (output valid, opcode, index, value, input ready);
	modport sink   (input valid, opcode, index, value, output ready);
endinterface

interface ctcr_out_if;
	logic        valid;
	logic        ready;
	logic [1:0]  out_channel;
	logic [14:0] activation;
	logic        last_result;

	modport source (output valid, out_channel, activation, last_result, input ready);
	modport sink   (input valid, out_channel, activation, last_result, output ready);
endinterface
`default_nettype wire

[sv/ctcr_ram.sv]
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// ctcr_ram
// Simple dual-port RAM, one write port and one registered read port.
// ---------------------------------------------------------------------------
module ctcr_ram #(
	parameter int DEPTH = 16,
	parameter int WIDTH = 16,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

[sv/ctcr_mac.sv]
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// ctcr_mac
// Shared multiply-accumulate unit: registered product, then accumulate.
// ---------------------------------------------------------------------------
module ctcr_mac (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire ctcr_pkg::mac_ctl_t                   ctl,
	input  wire logic signed [ctcr_pkg::DATA_W-1:0]   w,
	input  wire logic signed [ctcr_pkg::DATA_W-1:0]   x,
	output logic signed      [ctcr_pkg::ACC_W-1:0]    acc,
	output logic                                      done
);

	ctcr_pkg::mac_ctl_t                   ctl_s2;
	logic signed [ctcr_pkg::PROD_W-1:0]   prod_s2;
	logic signed [ctcr_pkg::ACC_W-1:0]    acc_q;
	logic                                 done_q;

	// product stage payload
	always_ff @(posedge clk) begin
		prod_s2 <= w * x;
	end

	// product stage control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s2 <= '0;
		end else begin
			ctl_s2 <= ctl;
		end
	end

	// accumulator, restarted on the first pair of a sum
	always_ff @(posedge clk) begin
		if (ctl_s2.vld) begin
			if (ctl_s2.first) begin
				acc_q <= ctcr_pkg::ACC_W'(prod_s2);
			end else begin
				acc_q <= acc_q + ctcr_pkg::ACC_W'(prod_s2);
			end
		end
	end

	// sum complete after the last pair
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= ctl_s2.vld & ctl_s2.last;
		end
	end

	assign acc  = acc_q;
	assign done = done_q;

endmodule
`default_nettype wire

[sv/causal_temporal_conv_relu_core.sv]
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// causal_temporal_conv_relu_core
// Causal 1-D convolution with ReLU over a ring of recent input vectors.
// ---------------------------------------------------------------------------
// A weight load, an out-of-range item and a sample for any channel but the
// last are accepted in the idle state. The sample for the last input channel
// commits the vector and starts the convolution: one multiply-accumulate unit
// walks all TAPS*IN_CH weight/history pairs of each output channel, so a
// commit keeps the input not ready until the last result enters the output
// register, longer if results are not taken. Weights and history sit in RAMs
// with registered reads; history reads as zero until written. Results come
// out in output-channel order, the last one flagged.
// ---------------------------------------------------------------------------
module causal_temporal_conv_relu_core (
	input  wire logic     clk,
	input  wire logic     arst_n,
	ctcr_in_if.sink       req,
	ctcr_out_if.source    rsp
);

	localparam int HA_W = ctcr_pkg::HA_W;
	localparam int WA_W = ctcr_pkg::WA_W;
	localparam int IC_W = ctcr_pkg::IC_W;
	localparam int OC_W = ctcr_pkg::OC_W;
	localparam int TK_W = ctcr_pkg::TK_W;
	localparam int HIST_VLD_N = ctcr_pkg::HIST_SIZE;

	ctcr_pkg::state_t state_q, state_d;

	logic [IC_W-1:0] i_q;
	logic [TK_W-1:0] k_q;
	logic [OC_W-1:0] o_q;
	logic [HA_W-1:0] ring_base_q;
	logic [HA_W-1:0] hist_base_q;
	logic [WA_W-1:0] w_base_q;
	logic [WA_W-1:0] wo_base_q;

	logic req_fire;
	logic load_ok;
	logic sample_ok;
	logic commit;
	logic last_i;
	logic last_k;
	logic last_o;
	logic issue;
	logic put;

	logic [HA_W-1:0] hist_waddr;
	logic [HA_W-1:0] hist_raddr;
	logic [WA_W-1:0] w_waddr;
	logic [WA_W-1:0] w_raddr;
	logic [ctcr_pkg::DATA_W-1:0] hist_rdata;
	logic [ctcr_pkg::DATA_W-1:0] w_rdata;
	logic [HIST_VLD_N-1:0] hist_vld_q;

	ctcr_pkg::mac_ctl_t ctl_s0, ctl_s1;
	logic hvld_s1;
	logic signed [ctcr_pkg::DATA_W-1:0] x_s1;
	logic signed [ctcr_pkg::ACC_W-1:0] acc;
	logic signed [ctcr_pkg::ACC_W-1:0] acc_sh;
	logic mac_done;
	logic [ctcr_pkg::ACT_W-1:0] act;

	logic [ctcr_pkg::ACT_W-1:0] res_q;
	logic                       out_valid_q;
	logic [1:0]                 out_ch_q;
	logic [ctcr_pkg::ACT_W-1:0] out_act_q;
	logic                       out_last_q;

	// input transaction decode
	assign req_fire  = req.valid & req.ready;
	assign load_ok   = req_fire && (req.opcode == ctcr_pkg::OP_LOAD) &&
		(int'(req.index) < ctcr_pkg::WEIGHT_SIZE);
	assign sample_ok = req_fire && (req.opcode == ctcr_pkg::OP_SAMPLE) &&
		(int'(req.index) < ctcr_pkg::IN_CH);
	assign commit    = sample_ok && (int'(req.index) == ctcr_pkg::IN_CH - 1);

	// sequencer position flags
	assign last_i = (i_q == IC_W'(ctcr_pkg::IN_CH - 1));
	assign last_k = (k_q == TK_W'(ctcr_pkg::TAPS - 1));
	assign last_o = (o_q == OC_W'(ctcr_pkg::OUT_CH - 1));

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ctcr_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and sequencer outputs
	always_comb begin
		state_d   = state_q;
		req.ready = 1'b0;
		issue     = 1'b0;
		put       = 1'b0;
		unique case (state_q)
			ctcr_pkg::ST_IDLE: begin
				req.ready = 1'b1;
				if (commit) begin
					state_d = ctcr_pkg::ST_ISSUE;
				end
			end
			ctcr_pkg::ST_ISSUE: begin
				issue = 1'b1;
				if (last_i && last_k) begin
					state_d = ctcr_pkg::ST_WAIT;
				end
			end
			ctcr_pkg::ST_WAIT: begin
				if (mac_done) begin
					state_d = ctcr_pkg::ST_PUT;
				end
			end
			ctcr_pkg::ST_PUT: begin
				if (!out_valid_q || rsp.ready) begin
					put     = 1'b1;
					state_d = last_o ? ctcr_pkg::ST_IDLE : ctcr_pkg::ST_ISSUE;
				end
			end
			default: begin
				state_d = ctcr_pkg::ST_IDLE;
			end
		endcase
	end

	// tap, channel and base address counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			i_q         <= '0;
			k_q         <= '0;
			o_q         <= '0;
			ring_base_q <= '0;
			hist_base_q <= '0;
			w_base_q    <= '0;
			wo_base_q   <= '0;
		end else begin
			if (commit) begin
				i_q         <= '0;
				k_q         <= '0;
				o_q         <= '0;
				hist_base_q <= ring_base_q;
				w_base_q    <= '0;
				wo_base_q   <= '0;
			end
			if (issue) begin
				if (last_i) begin
					i_q      <= '0;
					k_q      <= k_q + TK_W'(1);
					w_base_q <= w_base_q + WA_W'(ctcr_pkg::OUT_CH * ctcr_pkg::IN_CH);
					// older vectors sit one slot back, wrapping around the ring
					if (hist_base_q == '0) begin
						hist_base_q <= HA_W'((ctcr_pkg::TAPS - 1) * ctcr_pkg::IN_CH);
					end else begin
						hist_base_q <= hist_base_q - HA_W'(ctcr_pkg::IN_CH);
					end
				end else begin
					i_q <= i_q + IC_W'(1);
				end
			end
			if (put) begin
				i_q         <= '0;
				k_q         <= '0;
				o_q         <= o_q + OC_W'(1);
				hist_base_q <= ring_base_q;
				w_base_q    <= wo_base_q + WA_W'(ctcr_pkg::IN_CH);
				wo_base_q   <= wo_base_q + WA_W'(ctcr_pkg::IN_CH);
				// the ring advances once all channels are out
				if (last_o) begin
					if (int'(ring_base_q) == ctcr_pkg::HIST_SIZE - ctcr_pkg::IN_CH) begin
						ring_base_q <= '0;
					end else begin
						ring_base_q <= ring_base_q + HA_W'(ctcr_pkg::IN_CH);
					end
				end
			end
		end
	end

	// memory addresses
	assign hist_waddr = HA_W'(ring_base_q + HA_W'(req.index));
	assign hist_raddr = HA_W'(hist_base_q + HA_W'(i_q));
	assign w_waddr    = WA_W'(req.index);
	assign w_raddr    = WA_W'(w_base_q + WA_W'(i_q));

	ctcr_ram #(
		.DEPTH (ctcr_pkg::WEIGHT_SIZE),
		.WIDTH (ctcr_pkg::DATA_W)
	) u_weight_ram (
		.clk   (clk),
		.we    (load_ok),
		.waddr (w_waddr),
		.wdata (req.value),
		.raddr (w_raddr),
		.rdata (w_rdata)
	);

	ctcr_ram #(
		.DEPTH (ctcr_pkg::HIST_SIZE),
		.WIDTH (ctcr_pkg::DATA_W)
	) u_hist_ram (
		.clk   (clk),
		.we    (sample_ok),
		.waddr (hist_waddr),
		.wdata (req.value),
		.raddr (hist_raddr),
		.rdata (hist_rdata)
	);

	// history entries read as zero until first written
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hist_vld_q <= '0;
			hvld_s1    <= 1'b0;
		end else begin
			if (sample_ok) begin
				hist_vld_q[hist_waddr] <= 1'b1;
			end
			hvld_s1 <= hist_vld_q[hist_raddr];
		end
	end

	// control aligned with the registered memory reads
	assign ctl_s0.vld   = issue;
	assign ctl_s0.first = issue && (i_q == '0) && (k_q == '0);
	assign ctl_s0.last  = issue && last_i && last_k;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else begin
			ctl_s1 <= ctl_s0;
		end
	end

	assign x_s1 = hvld_s1 ? $signed(hist_rdata) : '0;

	ctcr_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl_s1),
		.w      ($signed(w_rdata)),
		.x      (x_s1),
		.acc    (acc),
		.done   (mac_done)
	);

	// relu, drop fraction bits, saturate at the top
	assign acc_sh = acc >>> ctcr_pkg::FRAC_W;
	always_comb begin
		if (acc <= 0) begin
			act = '0;
		end else if (|acc_sh[ctcr_pkg::ACC_W-1:ctcr_pkg::ACT_W]) begin
			act = '1;
		end else begin
			act = acc_sh[ctcr_pkg::ACT_W-1:0];
		end
	end

	// hold the finished activation until the output register frees up
	always_ff @(posedge clk) begin
		if (mac_done) begin
			res_q <= act;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (put) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (put) begin
			out_ch_q   <= 2'(o_q);
			out_act_q  <= res_q;
			out_last_q <= last_o;
		end
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.out_channel = out_ch_q;
	assign rsp.activation  = out_act_q;
	assign rsp.last_result = out_last_q;

	// checks
	a_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		mac_done |-> state_q == ctcr_pkg::ST_WAIT)
		else $error("sum finished outside wait state");

	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		req.ready |-> !out_valid_q || state_q == ctcr_pkg::ST_IDLE)
		else $error("input ready while sequencer busy");

	a_ring_range: assert property (@(posedge clk) disable iff (!arst_n)
		int'(ring_base_q) <= ctcr_pkg::HIST_SIZE - ctcr_pkg::IN_CH)
		else $error("ring base out of range");

	a_put_then_issue: assert property (@(posedge clk) disable iff (!arst_n)
		put && !last_o |=> state_q == ctcr_pkg::ST_ISSUE && i_q == '0 && k_q == '0)
		else $error("next output channel did not restart at tap zero");

	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		put && last_o |=> state_q == ctcr_pkg::ST_IDLE && out_valid_q && out_last_q)
		else $error("final result not flagged");

endmodule
`default_nettype wire

[dv/testbench.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench
// Checks the causal convolution core against a behavioral model of the layer.
// All weights are loaded first, then a table of directed transactions covers
// the field extremes, both opcodes, ignored indexes, ring wrap and partly
// written vectors. Random vectors, weight loads and noise follow. Every
// activation is compared with the model or with the row's typed-in values.
// ---------------------------------------------------------------------------
module testbench;

	localparam int RANDOM_ITEMS = 336;
	localparam int HOLD_CYCLES  = 800;
	localparam int DRAIN_CYCLES = 300;
	localparam int LIMIT_CYCLES = 1000000;
	localparam logic [ctcr_pkg::ACT_W-1:0] ACT_SAT = 15'h7fff;

	// one directed row: transaction plus optional typed-in activations
	typedef struct packed {
		logic                                op;
		logic [6:0]                          idx;
		logic signed [ctcr_pkg::DATA_W-1:0]  val;
		logic                                chk;
		logic [0:3][ctcr_pkg::ACT_W-1:0]     acts;
	} dir_row_t;

	typedef struct packed {
		logic [1:0]                 out_channel;
		logic [ctcr_pkg::ACT_W-1:0] activation;
		logic                       last_result;
	} act_rec_t;

	localparam int NROWS = 21;
	localparam dir_row_t DIR_ROWS [NROWS] = '{
		'{ctcr_pkg::OP_LOAD,   7'd0,   16'sh7fff, 1'b0, '0},
		'{ctcr_pkg::OP_LOAD,   7'd10,  16'sh8000, 1'b0, '0},
		'{ctcr_pkg::OP_LOAD,   7'd20,  16'sh4000, 1'b0, '0},
		'{ctcr_pkg::OP_LOAD,   7'd120, 16'sh7fff, 1'b0, '0},
		'{ctcr_pkg::OP_LOAD,   7'd127, 16'shffff, 1'b0, '0},
		'{ctcr_pkg::OP_SAMPLE, 7'd0,   16'sh7fff, 1'b0, '0},
		'{ctcr_pkg::OP_SAMPLE, 7'd10,  16'sh7fff, 1'b0, '0},
		'{ctcr_pkg::OP_SAMPLE, 7'd127, 16'sh8000, 1'b0, '0},
		'{ctcr_pkg::OP_SAMPLE, 7'd9,   16'sh8000, 1'b1,
			{15'd32767, 15'd0, 15'd32767, 15'd0}},
		'{ctcr_pkg::OP_SAMPLE, 7'd0,   16'sh0001, 1'b0, '0},
		'{ctcr_pkg::OP_SAMPLE, 7'd9,   16'sh0000, 1'b1, {15'd7, 15'd0, 15'd4, 15'd0}},
		'{ctcr_pkg::OP_LOAD,   7'd115, 16'sh1000, 1'b0, '0},
		'{ctcr_pkg::OP_LOAD,   7'd49,  16'sh7fff, 1'b0, '0},
		'{ctcr_pkg::OP_SAMPLE, 7'd5,   16'sh2000, 1'b0, '0},
		'{ctcr_pkg::OP_SAMPLE, 7'd9,   16'sh1000, 1'b0, '0},
		'{ctcr_pkg::OP_SAMPLE, 7'd9,   16'sh0800, 1'b0, '0},
		'{ctcr_pkg::OP_LOAD,   7'd119, 16'sh8000, 1'b0, '0},
		'{ctcr_pkg::OP_LOAD,   7'd39,  16'sh7fff, 1'b0, '0},
		'{ctcr_pkg::OP_SAMPLE, 7'd3,   16'shffff, 1'b0, '0},
		'{ctcr_pkg::OP_SAMPLE, 7'd9,   16'sh7fff, 1'b0, '0},
		'{ctcr_pkg::OP_SAMPLE, 7'd9,   16'sh8000, 1'b0, '0}
	};

	logic clk = 1'b0;
	logic arst_n;

	ctcr_in_if  req_if ();
	ctcr_out_if rsp_if ();

	causal_temporal_conv_relu_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_if),
		.rsp    (rsp_if)
	);

	// layer state as the core should hold it
	logic signed [ctcr_pkg::DATA_W-1:0] hist_mem [ctcr_pkg::HIST_SIZE];
	logic signed [ctcr_pkg::DATA_W-1:0] wt_mem [ctcr_pkg::WEIGHT_SIZE];
	int                                 slot_ptr;
	logic [ctcr_pkg::ACT_W-1:0]         layer_acts [ctcr_pkg::OUT_CH];

	act_rec_t acts_due [$];
	int       errors;
	bit       calm;
	bit       hold_off;
	int       cycle_count;

	// clock
	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// apply one transaction to the layer state, true when it commits a vector
	function automatic bit step_layer(input logic op, input logic [6:0] idx,
		input logic signed [ctcr_pkg::DATA_W-1:0] val);
		longint acc;
		int     slot;
		bit     commit;
		commit = 1'b0;
		if (op == ctcr_pkg::OP_LOAD) begin
			if (idx < ctcr_pkg::WEIGHT_SIZE)
				wt_mem[idx] = val;
		end else if (idx < ctcr_pkg::IN_CH) begin
			hist_mem[slot_ptr * ctcr_pkg::IN_CH + idx] = val;
			if (idx == ctcr_pkg::IN_CH - 1) begin
				for (int o = 0; o < ctcr_pkg::OUT_CH; o++) begin
					acc = 0;
					// newest vector is tap 0, older ones read backward around the ring
					for (int k = 0; k < ctcr_pkg::TAPS; k++) begin
						slot = (slot_ptr + ctcr_pkg::TAPS - k) % ctcr_pkg::TAPS;
						for (int i = 0; i < ctcr_pkg::IN_CH; i++)
							acc += longint'(wt_mem[(k * ctcr_pkg::OUT_CH + o) *
								ctcr_pkg::IN_CH + i]) *
								longint'(hist_mem[slot * ctcr_pkg::IN_CH + i]);
					end
					if (acc <= 0) begin
						layer_acts[o] = '0;
					end else begin
						acc = acc >>> ctcr_pkg::FRAC_W;
						layer_acts[o] = (acc > longint'(ACT_SAT)) ? ACT_SAT :
							acc[ctcr_pkg::ACT_W-1:0];
					end
				end
				slot_ptr = (slot_ptr + 1) % ctcr_pkg::TAPS;
				commit = 1'b1;
			end
		end
		return commit;
	endfunction

	function automatic logic signed [ctcr_pkg::DATA_W-1:0] rand_value();
		int r;
		r = $urandom_range(0, 9);
		if (r < 5)
			return 16'($urandom_range(0, 4095) - 2048);
		else if (r < 8)
			return 16'($urandom_range(0, 16383) - 8192);
		return 16'($urandom);
	endfunction

	// offer one transaction after a random gap, then record its activations
	task automatic send_item(input dir_row_t row);
		int       gap;
		act_rec_t rec;
		gap = calm ? 0 : $urandom_range(0, 10);
		if (gap > 0) begin
			req_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_if.valid  <= 1'b1;
		req_if.opcode <= row.op;
		req_if.index  <= row.idx;
		req_if.value  <= row.val;
		do @(posedge clk); while (!req_if.ready);
		if (step_layer(row.op, row.idx, row.val)) begin
			for (int o = 0; o < ctcr_pkg::OUT_CH; o++) begin
				rec.out_channel = o[1:0];
				rec.activation  = (row.chk && o < 4) ? row.acts[o] : layer_acts[o];
				rec.last_result = (o == ctcr_pkg::OUT_CH - 1);
				acts_due.push_back(rec);
			end
		end
	endtask

	// stimulus
	initial begin
		dir_row_t row;
		int       sent;
		int       kind;
		int       n;
		int       chans [ctcr_pkg::IN_CH-1];
		int       j;
		int       t;

		errors   = 0;
		calm     = 1'b0;
		hold_off = 1'b0;
		slot_ptr = 0;
		for (int i = 0; i < ctcr_pkg::HIST_SIZE; i++)
			hist_mem[i] = '0;
		arst_n        = 1'b0;
		req_if.valid  = 1'b0;
		req_if.opcode = ctcr_pkg::OP_LOAD;
		req_if.index  = '0;
		req_if.value  = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// every weight is written before the first commit
		for (int k = 0; k < ctcr_pkg::WEIGHT_SIZE; k++) begin
			row = '{ctcr_pkg::OP_LOAD, 7'(k), 16'sd0, 1'b0, '0};
			send_item(row);
		end

		// directed table
		for (int r = 0; r < NROWS; r++)
			send_item(DIR_ROWS[r]);

		// receiver holds off once while vectors keep coming
		hold_off = 1'b1;
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			calm = ($urandom_range(0, 4) == 0);
			kind = $urandom_range(0, 99);
			if (kind < 65) begin
				// full vector, channels in random order, last channel commits
				for (int i = 0; i < ctcr_pkg::IN_CH - 1; i++)
					chans[i] = i;
				for (int i = ctcr_pkg::IN_CH - 2; i > 0; i--) begin
					j = $urandom_range(0, i);
					t = chans[i];
					chans[i] = chans[j];
					chans[j] = t;
				end
				for (int i = 0; i < ctcr_pkg::IN_CH - 1; i++) begin
					row = '{ctcr_pkg::OP_SAMPLE, 7'(chans[i]), rand_value(), 1'b0, '0};
					send_item(row);
				end
				row = '{ctcr_pkg::OP_SAMPLE, 7'(ctcr_pkg::IN_CH - 1), rand_value(),
					1'b0, '0};
				send_item(row);
				sent += ctcr_pkg::IN_CH;
			end else if (kind < 80) begin
				// burst of weight updates
				n = $urandom_range(1, 6);
				for (int i = 0; i < n; i++) begin
					row = '{ctcr_pkg::OP_LOAD,
						7'($urandom_range(0, ctcr_pkg::WEIGHT_SIZE - 1)), rand_value(),
						1'b0, '0};
					send_item(row);
				end
				sent += n;
			end else if (kind < 92) begin
				// out-of-range indexes, ignored by the core
				n = $urandom_range(1, 3);
				for (int i = 0; i < n; i++) begin
					if ($urandom_range(0, 1) == 0)
						row = '{ctcr_pkg::OP_LOAD,
							7'($urandom_range(ctcr_pkg::WEIGHT_SIZE, 127)),
							16'($urandom), 1'b0, '0};
					else
						row = '{ctcr_pkg::OP_SAMPLE,
							7'($urandom_range(ctcr_pkg::IN_CH, 127)),
							16'($urandom), 1'b0, '0};
					send_item(row);
				end
				sent += n;
			end else begin
				// partly written vector, committed or left open
				n = $urandom_range(0, 4);
				for (int i = 0; i < n; i++) begin
					row = '{ctcr_pkg::OP_SAMPLE,
						7'($urandom_range(0, ctcr_pkg::IN_CH - 2)), rand_value(),
						1'b0, '0};
					send_item(row);
				end
				sent += n;
				if ($urandom_range(0, 1) == 1) begin
					row = '{ctcr_pkg::OP_SAMPLE, 7'(ctcr_pkg::IN_CH - 1), rand_value(),
						1'b0, '0};
					send_item(row);
					sent += 1;
				end
			end
		end
		req_if.valid <= 1'b0;
		calm = 1'b0;

		// drain
		while (acts_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("testbench: PASS");
		else
			$display("testbench: FAIL");
		$finish;
	end

	// result side ready, with random gaps and one long hold-off
	initial begin
		int gap;
		rsp_if.ready = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			gap = calm ? 0 : $urandom_range(0, 10);
			if (hold_off) begin
				gap = HOLD_CYCLES;
				hold_off = 1'b0;
			end
			if (gap > 0) begin
				rsp_if.ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			rsp_if.ready <= 1'b1;
			do @(posedge clk); while (!rsp_if.valid);
		end
	end

	// compare each activation transaction with the oldest prediction
	always @(posedge clk) begin
		act_rec_t want;
		if (arst_n && rsp_if.valid && rsp_if.ready) begin
			if (acts_due.size() == 0) begin
				$error("activation transaction with none expected: channel %0d value %0d",
					rsp_if.out_channel, rsp_if.activation);
				errors++;
			end else begin
				want = acts_due.pop_front();
				if (rsp_if.out_channel !== want.out_channel) begin
					$error("out_channel: expected %0d, got %0d",
						want.out_channel, rsp_if.out_channel);
					errors++;
				end
				if (rsp_if.activation !== want.activation) begin
					$error("activation: expected %0d, got %0d",
						want.activation, rsp_if.activation);
					errors++;
				end
				if (rsp_if.last_result !== want.last_result) begin
					$error("last_result: expected %0d, got %0d",
						want.last_result, rsp_if.last_result);
					errors++;
				end
			end
		end
	end

	// run limit
	initial begin
		cycle_count = 0;
		while (cycle_count < LIMIT_CYCLES) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("testbench: FAIL");
		$finish;
	end

endmodule
